// File: sv/shps_pkg.sv
`default_nettype none

package shps_pkg;

    localparam int BYTE_W     = 8;
    localparam int PAT_BYTES  = 16;
    localparam int PAT_IDX_W  = 4;
    localparam int SUM_W      = 12;
    localparam int INDEX_W    = 16;
    localparam int LEN_CFG_W  = 5;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    typedef logic [BYTE_W-1:0] t_byte;

    // register slots, 8 bytes apart
    typedef enum logic [1:0] {
        REG_LENGTH,
        REG_PAT_LOW,
        REG_PAT_HIGH
    } t_reg_idx;

    // per-cell compare setup, derived from the pattern registers
    typedef struct packed {
        logic  active;
        t_byte pat;
    } t_cell_cfg;

endpackage

`default_nettype wire

// File: sv/shps_if.sv
`default_nettype none

interface shps_in_if
    import shps_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  start_of_text;

    modport source (output valid, output text_byte, output start_of_text, input ready);
    modport sink   (input valid, input text_byte, input start_of_text, output ready);
endinterface

interface shps_out_if
    import shps_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] start_index;

    modport source (output valid, output found, output start_index, input ready);
    modport sink   (input valid, input found, input start_index, output ready);
endinterface

`default_nettype wire

// File: sv/shps_cell.sv
`default_nettype none

module shps_cell
    import shps_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_shift,
    input  wire t_byte     i_byte,
    input  wire t_cell_cfg i_cfg,
    output t_byte          o_byte,
    output t_byte          o_term,
    output logic           o_eq
);

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    // cells past the pattern length add nothing and always agree
    assign o_term = i_cfg.active ? r_byte : '0;
    assign o_eq   = !i_cfg.active || (r_byte == i_cfg.pat);

endmodule

`default_nettype wire

// File: sv/sum_hash_pattern_search.sv
// Channel  Dir  Handshake     Word
// i_text   in   valid/ready   text_byte, start_of_text
// o_match  out  valid/ready   found, start_index
// apb      in   psel/penable  pattern_length @0x00, pattern_bytes_low @0x08, _high @0x10
//
// One text word per cycle while the output is not stalled; a result is offered only
// where the window sum matches the pattern sum, after the cell row shift, the registered
// sums of four-byte groups and the final sum compare into the output register.
// When the output register is full and not taken the whole pipeline holds.
// Synchronous active-low reset clears length to 1, pattern to zero, fill and position.
`default_nettype none

module sum_hash_pattern_search
    import shps_pkg::*;
#(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    shps_in_if.sink                    i_text,
    shps_out_if.source                 o_match,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int GROUPS = (MAX_PATTERN + 3) / 4;
    localparam int PART_W = BYTE_W + 2;
    localparam int TAKE_W = (POSITION_BITS < INDEX_W) ? POSITION_BITS : INDEX_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // configuration
    logic [LEN_CFG_W-1:0]  r_len;
    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic                  w_wr;
    t_reg_idx              w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = t_reg_idx'(paddr[CFG_ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LEN_CFG_W'(1);
            r_pat_low  <= '0;
            r_pat_high <= '0;
        end else if (w_wr) begin
            case (w_reg)
                REG_LENGTH:   r_len      <= pwdata[LEN_CFG_W-1:0];
                REG_PAT_LOW:  r_pat_low  <= pwdata;
                REG_PAT_HIGH: r_pat_high <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_LENGTH:   prdata = CFG_DATA_W'(r_len);
            REG_PAT_LOW:  prdata = r_pat_low;
            REG_PAT_HIGH: prdata = r_pat_high;
            default:      prdata = '0;
        endcase
    end

    // derived pattern setup, refreshed every cycle; to be written only while idle (not enforced)
    t_byte               w_pat [PAT_BYTES];
    logic [LEN_W-1:0]    w_eff;
    logic [LEN_CFG_W-1:0] w_al [MAX_PATTERN];
    t_cell_cfg           w_cell_cfg [MAX_PATTERN];
    logic [PART_W-1:0]   w_pat_part [GROUPS];
    logic [SUM_W-1:0]    w_pat_total;

    logic [LEN_W-1:0]    r_eff;
    t_cell_cfg           r_cell_cfg [MAX_PATTERN];
    logic [PART_W-1:0]   r_pat_part [GROUPS];
    logic [SUM_W-1:0]    r_pat_sum;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_pat[j]     = r_pat_low[8*j +: 8];
            w_pat[j + 8] = r_pat_high[8*j +: 8];
        end
        if (r_len == '0) begin
            w_eff = LEN_W'(1);
        end else if (r_len > LEN_CFG_W'(MAX_PATTERN)) begin
            w_eff = LEN_W'(MAX_PATTERN);
        end else begin
            w_eff = LEN_W'(r_len);
        end
        // cell k compares with pattern byte len-1-k (oldest byte against byte 0)
        for (int k = 0; k < MAX_PATTERN; k++) begin
            w_al[k] = LEN_CFG_W'(w_eff) - LEN_CFG_W'(1) - LEN_CFG_W'(k);
            w_cell_cfg[k].active = (k < int'(w_eff));
            w_cell_cfg[k].pat    = w_pat[w_al[k][PAT_IDX_W-1:0]];
        end
        for (int g = 0; g < GROUPS; g++) begin
            w_pat_part[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if ((4*g + j) < int'(w_eff)) begin
                    w_pat_part[g] = w_pat_part[g] + PART_W'(w_pat[4*g + j]);
                end
            end
        end
        w_pat_total = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_pat_total = w_pat_total + SUM_W'(r_pat_part[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_eff      <= w_eff;
        r_cell_cfg <= w_cell_cfg;
        r_pat_part <= w_pat_part;
        r_pat_sum  <= w_pat_total;
    end

    // pipeline control
    logic w_en;
    logic w_acc;

    assign w_en         = !r_o_valid || o_match.ready;
    assign i_text.ready = i_rst_n && w_en;
    assign w_acc        = i_text.valid && i_text.ready;

    // row of window cells, cell 0 newest
    t_byte w_chain_in [MAX_PATTERN];
    t_byte w_byte     [MAX_PATTERN];
    t_byte w_term     [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_eq;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_chain_in[k] = i_text.text_byte;
        end else begin : g_link
            assign w_chain_in[k] = w_byte[k-1];
        end
        shps_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_acc),
            .i_byte  (w_chain_in[k]),
            .i_cfg   (r_cell_cfg[k]),
            .o_byte  (w_byte[k]),
            .o_term  (w_term[k]),
            .o_eq    (w_eq[k])
        );
    end

    // fill count and position
    logic [LEN_W-1:0]         r_fill;
    logic [LEN_W-1:0]         n_fill;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] w_pos_base;
    logic [LEN_W-1:0]         w_fill_base;

    always_comb begin
        w_fill_base = i_text.start_of_text ? '0 : r_fill;
        w_pos_base  = i_text.start_of_text ? '0 : r_pos;
        n_fill = (w_fill_base < LEN_W'(MAX_PATTERN)) ? w_fill_base + LEN_W'(1) : w_fill_base;
        n_pos  = (w_pos_base == POS_MAX) ? w_pos_base : w_pos_base + POSITION_BITS'(1);
    end

    // stage registers
    logic                     r_s1_valid;
    logic [POSITION_BITS-1:0] r_s1_pos;
    logic                     r_s2_valid;
    logic [PART_W-1:0]        r_s2_part [GROUPS];
    logic                     r_s2_eq;
    logic [INDEX_W-1:0]       r_s2_index;
    logic                     r_o_valid;
    logic                     r_o_found;
    logic [INDEX_W-1:0]       r_o_index;

    logic [PART_W-1:0]        w_win_part [GROUPS];
    logic [SUM_W-1:0]         w_win_sum;
    logic                     w_hit;

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            w_win_part[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if ((4*g + j) < MAX_PATTERN) begin
                    w_win_part[g] = w_win_part[g] + PART_W'(w_term[4*g + j]);
                end
            end
        end
        w_win_sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_win_sum = w_win_sum + SUM_W'(r_s2_part[g]);
        end
        w_hit = r_s2_valid && (w_win_sum == r_pat_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_en) begin
            if (w_acc) begin
                r_fill <= n_fill;
                r_pos  <= n_pos;
            end
            r_s1_valid <= w_acc;
            r_s2_valid <= r_s1_valid && (r_fill >= r_eff);
            r_o_valid  <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_acc) begin
                r_s1_pos <= w_pos_base;
            end
            r_s2_part  <= w_win_part;
            r_s2_eq    <= &w_eq;
            r_s2_index <= INDEX_W'(r_s1_pos[TAKE_W-1:0]) - INDEX_W'(r_eff) + INDEX_W'(1);
            r_o_found  <= r_s2_eq;
            r_o_index  <= r_s2_index;
        end
    end

    assign o_match.valid       = r_o_valid;
    assign o_match.found       = r_o_found;
    assign o_match.start_index = r_o_index;

    // a restart leaves exactly one word in the window
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_text.start_of_text) |=> (r_fill == LEN_W'(1)) && (r_pos == POSITION_BITS'(1)))
        else $error("restart did not reset fill and position");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_text.start_of_text && (r_pos == POS_MAX)) |=> (r_pos == POS_MAX))
        else $error("position left saturation");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_s1_valid) && $stable(r_s2_valid) && $stable(r_fill))
        else $error("pipeline moved while output stalled");

    a_s2_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s2_valid) |-> $past(r_s1_valid))
        else $error("compare stage valid without a shifted word");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_fill != '0))
        else $error("result candidate with empty window");

endmodule

`default_nettype wire
